// ===== hdl/gps_pkg.sv =====
// Shared types and constants for the glitch pulse sequencer.
`default_nettype none

package gps_pkg;

    // Fixed field widths
    localparam int TIME_W   = 16;
    localparam int DLY_W    = 10;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 2;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = 3;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_POLARITY  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_WIDTH = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INIT_WIDTH = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH_INC = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH_DEC = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DEB_DELAY = 3'd5;

    // Register reset values
    localparam logic [TIME_W-1:0] RST_MAX_WIDTH  = 16'd100;
    localparam logic [TIME_W-1:0] RST_INIT_WIDTH = 16'd0;
    localparam logic [TIME_W-1:0] RST_WIDTH_INC  = 16'd1;
    localparam logic [TIME_W-1:0] RST_WIDTH_DEC  = 16'd1;
    localparam logic [DLY_W-1:0]  RST_DEB_DELAY  = 10'd10;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_IDLE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BUSY  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ERROR = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE       = 3'd0,
        MODE_SINGLE     = 3'd1,
        MODE_ON_EDGE    = 3'd2,
        MODE_SWEEP_UP   = 3'd3,
        MODE_SWEEP_DOWN = 3'd4,
        MODE_STEP_UP    = 3'd5,
        MODE_STEP_DOWN  = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        PH_WAIT  = 2'd0,
        PH_PULSE = 2'd1,
        PH_GAP   = 2'd2
    } phase_t;

    // Configuration register file contents
    typedef struct packed {
        logic              polarity;
        logic [TIME_W-1:0] max_width;
        logic [TIME_W-1:0] initial_width;
        logic [TIME_W-1:0] width_inc;
        logic [TIME_W-1:0] width_dec;
        logic [DLY_W-1:0]  deb_delay;
    } cfg_t;

    // One tick request as held in the input register
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              start_req;
        logic              abort;
        logic [TIME_W-1:0] pulse_width;
        logic [TIME_W-1:0] gap_ticks;
        logic              sense_level;
        logic              ms_mark;
    } req_t;

    // One result
    typedef struct packed {
        logic              fault_level;
        logic              pulse_on;
        logic [STAT_W-1:0] status;
        logic [TIME_W-1:0] width_now;
    } res_t;

endpackage

`default_nettype wire

// ===== hdl/gps_cfg.sv =====
// APB-style configuration register file.
`default_nettype none

module gps_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [gps_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [gps_pkg::DATA_W-1:0]  pwdata,
    output logic      [gps_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output gps_pkg::cfg_t                    cfg
);

    gps_pkg::cfg_t                       cfg_reg;
    logic [gps_pkg::REG_IDX_W-1:0]       reg_idx;
    logic                                wr_en;

    assign reg_idx = paddr[gps_pkg::ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.polarity      <= 1'b0;
            cfg_reg.max_width     <= gps_pkg::RST_MAX_WIDTH;
            cfg_reg.initial_width <= gps_pkg::RST_INIT_WIDTH;
            cfg_reg.width_inc     <= gps_pkg::RST_WIDTH_INC;
            cfg_reg.width_dec     <= gps_pkg::RST_WIDTH_DEC;
            cfg_reg.deb_delay     <= gps_pkg::RST_DEB_DELAY;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                gps_pkg::REG_POLARITY:   cfg_reg.polarity      <= pwdata[0];
                gps_pkg::REG_MAX_WIDTH:  cfg_reg.max_width     <= pwdata[gps_pkg::TIME_W-1:0];
                gps_pkg::REG_INIT_WIDTH: cfg_reg.initial_width <= pwdata[gps_pkg::TIME_W-1:0];
                gps_pkg::REG_WIDTH_INC:  cfg_reg.width_inc     <= pwdata[gps_pkg::TIME_W-1:0];
                gps_pkg::REG_WIDTH_DEC:  cfg_reg.width_dec     <= pwdata[gps_pkg::TIME_W-1:0];
                gps_pkg::REG_DEB_DELAY:  cfg_reg.deb_delay     <= pwdata[gps_pkg::DLY_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            gps_pkg::REG_POLARITY:   prdata = gps_pkg::DATA_W'(cfg_reg.polarity);
            gps_pkg::REG_MAX_WIDTH:  prdata = gps_pkg::DATA_W'(cfg_reg.max_width);
            gps_pkg::REG_INIT_WIDTH: prdata = gps_pkg::DATA_W'(cfg_reg.initial_width);
            gps_pkg::REG_WIDTH_INC:  prdata = gps_pkg::DATA_W'(cfg_reg.width_inc);
            gps_pkg::REG_WIDTH_DEC:  prdata = gps_pkg::DATA_W'(cfg_reg.width_dec);
            gps_pkg::REG_DEB_DELAY:  prdata = gps_pkg::DATA_W'(cfg_reg.deb_delay);
            default:                 prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/gps_debounce.sv =====
// Sense pin debounce filter with rising edge detect.
`default_nettype none

module gps_debounce #(
    parameter int DEBOUNCE_BITS = 10
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       sense_level,
    input  wire logic                       ms_mark,
    input  wire logic [gps_pkg::DLY_W-1:0]  deb_delay,
    output logic                            rise
);

    localparam int CMP_W = (DEBOUNCE_BITS > gps_pkg::DLY_W) ? DEBOUNCE_BITS : gps_pkg::DLY_W;

    logic                     raw_last_reg, raw_last_next;
    logic                     level_reg, level_next;
    logic [DEBOUNCE_BITS-1:0] stable_reg, stable_next;
    logic                     accept;

    // Stability counter and accepted level
    always_comb
    begin
        stable_next   = stable_reg;
        if (sense_level != raw_last_reg)
            stable_next = '0;
        else if (ms_mark && (stable_reg != '1))
            stable_next = stable_reg + 1'b1;
        raw_last_next = sense_level;

        accept = (CMP_W'(stable_next) > CMP_W'(deb_delay)) || (stable_next == '1);
        level_next = level_reg;
        rise       = 1'b0;
        if (accept && (sense_level != level_reg))
        begin
            level_next = sense_level;
            rise       = sense_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_last_reg <= 1'b0;
            level_reg    <= 1'b0;
            stable_reg   <= '0;
        end
        else if (en)
        begin
            raw_last_reg <= raw_last_next;
            level_reg    <= level_next;
            stable_reg   <= stable_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gps_core.sv =====
// Pulse sequencer state machine: mode, phase, counters and result logic.
`default_nettype none

module gps_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire gps_pkg::req_t req,
    input  wire logic          rise,
    input  wire gps_pkg::cfg_t cfg,
    output gps_pkg::res_t      res
);

    localparam int TW = gps_pkg::TIME_W;

    gps_pkg::mode_t  mode_reg, mode_next;
    gps_pkg::phase_t phase_reg, phase_next;
    logic [TW-1:0]   pulse_cnt_reg, pulse_cnt_next;
    logic [TW-1:0]   gap_cnt_reg, gap_cnt_next;
    logic [TW-1:0]   width_reg, width_next;
    logic            err_reg, err_next;

    logic            do_after;
    logic            do_sweep;
    logic            start_ok;
    logic [TW:0]     up_sum;
    logic [TW-1:0]   dn_diff;

    function automatic logic [TW:0] wide_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
        return {1'b0, a} + {1'b0, b};
    endfunction

    function automatic logic [TW-1:0] floor_sub(input logic [TW-1:0] a, input logic [TW-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    assign start_ok = req.start_req && !req.abort
                   && (req.mode != gps_pkg::MODE_NONE) && (req.mode <= gps_pkg::MODE_STEP_DOWN);

    // Next state
    always_comb
    begin
        mode_next      = mode_reg;
        phase_next     = phase_reg;
        pulse_cnt_next = pulse_cnt_reg;
        gap_cnt_next   = gap_cnt_reg;
        width_next     = width_reg;
        err_next       = err_reg;
        do_after       = 1'b0;
        do_sweep       = 1'b0;
        up_sum         = '0;
        dn_diff        = '0;

        // Tick of a running mode, or start from idle
        if (mode_reg != gps_pkg::MODE_NONE)
        begin
            if (req.abort)
            begin
                mode_next      = gps_pkg::MODE_NONE;
                phase_next     = gps_pkg::PH_WAIT;
                pulse_cnt_next = '0;
                gap_cnt_next   = '0;
            end
            else if (phase_reg == gps_pkg::PH_PULSE)
            begin
                pulse_cnt_next = pulse_cnt_reg - 1'b1;
                do_after       = (pulse_cnt_next == '0);
            end
            else if (phase_reg == gps_pkg::PH_GAP)
            begin
                if (gap_cnt_reg != '0)
                    gap_cnt_next = gap_cnt_reg - 1'b1;
                do_sweep = (gap_cnt_next == '0);
            end
            else if (rise)
            begin
                if (width_reg == '0)
                    do_after = 1'b1;
                else
                begin
                    phase_next     = gps_pkg::PH_PULSE;
                    pulse_cnt_next = width_reg;
                end
            end
        end
        else if (start_ok)
        begin
            if (((req.mode == gps_pkg::MODE_SWEEP_UP) && (cfg.width_inc == '0)) ||
                ((req.mode == gps_pkg::MODE_SWEEP_DOWN) && (cfg.width_dec == '0)))
                err_next = 1'b1;
            else
            begin
                err_next   = 1'b0;
                mode_next  = gps_pkg::mode_t'(req.mode);
                phase_next = gps_pkg::PH_WAIT;
                unique case (gps_pkg::mode_t'(req.mode))
                    gps_pkg::MODE_SINGLE:
                    begin
                        width_next = req.pulse_width;
                        if (req.pulse_width == '0)
                            do_after = 1'b1;
                        else
                        begin
                            phase_next     = gps_pkg::PH_PULSE;
                            pulse_cnt_next = req.pulse_width;
                        end
                    end
                    gps_pkg::MODE_ON_EDGE:
                        width_next = req.pulse_width;
                    gps_pkg::MODE_SWEEP_UP,
                    gps_pkg::MODE_SWEEP_DOWN:
                    begin
                        width_next = (req.mode == gps_pkg::MODE_SWEEP_UP) ?
                                     cfg.initial_width : cfg.max_width;
                        // empty sweep range ends at once
                        if (cfg.initial_width >= cfg.max_width)
                        begin
                            mode_next      = gps_pkg::MODE_NONE;
                            pulse_cnt_next = '0;
                            gap_cnt_next   = '0;
                        end
                        else if (width_next == '0)
                            do_after = 1'b1;
                        else
                        begin
                            phase_next     = gps_pkg::PH_PULSE;
                            pulse_cnt_next = width_next;
                        end
                    end
                    default:
                        width_next = cfg.initial_width;
                endcase
            end
        end

        // End of a pulse
        if (do_after)
        begin
            pulse_cnt_next = '0;
            case (mode_next)
                gps_pkg::MODE_SWEEP_UP,
                gps_pkg::MODE_SWEEP_DOWN:
                begin
                    phase_next   = gps_pkg::PH_GAP;
                    gap_cnt_next = req.gap_ticks;
                    do_sweep     = (req.gap_ticks == '0);
                end
                gps_pkg::MODE_STEP_UP:
                begin
                    up_sum     = wide_add(width_next, cfg.width_inc);
                    width_next = up_sum[TW] ? '1 : up_sum[TW-1:0];
                    phase_next = gps_pkg::PH_WAIT;
                end
                gps_pkg::MODE_STEP_DOWN:
                begin
                    width_next = floor_sub(width_next, cfg.width_dec);
                    phase_next = gps_pkg::PH_WAIT;
                end
                default:
                begin
                    mode_next      = gps_pkg::MODE_NONE;
                    phase_next     = gps_pkg::PH_WAIT;
                    gap_cnt_next   = '0;
                end
            endcase
        end

        // Next sweep width, or end of sweep
        if (do_sweep)
        begin
            up_sum  = wide_add(width_next, cfg.width_inc);
            dn_diff = floor_sub(width_next, cfg.width_dec);
            if (((mode_next == gps_pkg::MODE_SWEEP_UP) && (up_sum >= {1'b0, cfg.max_width})) ||
                ((mode_next != gps_pkg::MODE_SWEEP_UP) && (dn_diff <= cfg.initial_width)))
            begin
                mode_next      = gps_pkg::MODE_NONE;
                phase_next     = gps_pkg::PH_WAIT;
                pulse_cnt_next = '0;
                gap_cnt_next   = '0;
            end
            else
            begin
                width_next     = (mode_next == gps_pkg::MODE_SWEEP_UP) ? up_sum[TW-1:0] : dn_diff;
                phase_next     = gps_pkg::PH_PULSE;
                pulse_cnt_next = width_next;
            end
        end
    end

    // Result for this tick, from the state after it
    always_comb
    begin
        res.pulse_on    = (mode_next != gps_pkg::MODE_NONE) && (phase_next == gps_pkg::PH_PULSE);
        res.fault_level = res.pulse_on ^ cfg.polarity;
        if (mode_next != gps_pkg::MODE_NONE)
            res.status = gps_pkg::STAT_BUSY;
        else if (err_next)
            res.status = gps_pkg::STAT_ERROR;
        else
            res.status = gps_pkg::STAT_IDLE;
        res.width_now = width_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= gps_pkg::MODE_NONE;
            phase_reg     <= gps_pkg::PH_WAIT;
            pulse_cnt_reg <= '0;
            gap_cnt_reg   <= '0;
            width_reg     <= '0;
            err_reg       <= 1'b0;
        end
        else if (en)
        begin
            mode_reg      <= mode_next;
            phase_reg     <= phase_next;
            pulse_cnt_reg <= pulse_cnt_next;
            gap_cnt_reg   <= gap_cnt_next;
            width_reg     <= width_next;
            err_reg       <= err_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/glitch_pulse_sequencer_top.sv =====
// Glitch pulse sequencer: input register, sequencer core and result register.
//
// Usage: each request on the in_* channel is one microsecond tick carrying the
// mode, start and abort strobes, the raw sense pin and the millisecond mark.
// Every accepted request yields exactly one result on the out_* channel: the
// fault pin level, the pulse flag, the status and the current pulse width.
// Both channels use valid/ready; a transfer happens when both are high.
// A request accepted into the input register is processed by the core when it
// advances, and its result is then held in the result register.
// Throughput: one request per cycle while the result is not stalled; the
// sequencer state updates in logic between the input and result registers.
// Stall: a held result keeps its value; while it waits, the input register
// still accepts one more request, and ready drops only when both are full.
// Reset (rst_n low, asynchronous) clears both valid flags, returns the sequencer
// to idle and loads the register defaults. The user must write configuration
// through the APB-style port only while idle; the block does not enforce it.
`default_nettype none

module glitch_pulse_sequencer_top #(
    parameter int DEBOUNCE_BITS = 10
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // tick requests
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [gps_pkg::MODE_W-1:0]  mode,
    input  wire logic                        start_req,
    input  wire logic                        abort,
    input  wire logic [gps_pkg::TIME_W-1:0]  pulse_width,
    input  wire logic [gps_pkg::TIME_W-1:0]  gap_ticks,
    input  wire logic                        sense_level,
    input  wire logic                        ms_mark,
    // results
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             fault_level,
    output logic                             pulse_on,
    output logic      [gps_pkg::STAT_W-1:0]  status,
    output logic      [gps_pkg::TIME_W-1:0]  width_now,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [gps_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [gps_pkg::DATA_W-1:0]  pwdata,
    output logic      [gps_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    gps_pkg::cfg_t cfg;
    gps_pkg::req_t req_reg;
    gps_pkg::res_t res_comb;
    gps_pkg::res_t res_reg;
    logic          in_valid_reg, in_valid_next;
    logic          out_valid_reg, out_valid_next;
    logic          advance;
    logic          in_take;
    logic          rise;

    // Handshake
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg.mode        <= mode;
            req_reg.start_req   <= start_req;
            req_reg.abort       <= abort;
            req_reg.pulse_width <= pulse_width;
            req_reg.gap_ticks   <= gap_ticks;
            req_reg.sense_level <= sense_level;
            req_reg.ms_mark     <= ms_mark;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_comb;
    end

    gps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gps_debounce #(
        .DEBOUNCE_BITS (DEBOUNCE_BITS)
    ) u_debounce (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .sense_level (req_reg.sense_level),
        .ms_mark     (req_reg.ms_mark),
        .deb_delay   (cfg.deb_delay),
        .rise        (rise)
    );

    gps_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .req   (req_reg),
        .rise  (rise),
        .cfg   (cfg),
        .res   (res_comb)
    );

    assign out_valid   = out_valid_reg;
    assign fault_level = res_reg.fault_level;
    assign pulse_on    = res_reg.pulse_on;
    assign status      = res_reg.status;
    assign width_now   = res_reg.width_now;

endmodule

`default_nettype wire

// ===== hdl/gps_checker.sv =====
// Port-level checks for the glitch pulse sequencer, bound to the top level.
`default_nettype none

module gps_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic                        pulse_on,
    input  wire logic [gps_pkg::STAT_W-1:0]  status,
    input  wire logic [gps_pkg::TIME_W-1:0]  width_now,
    input  wire logic                        fault_level
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(width_now) && $stable(status)
                                    && $stable(pulse_on) && $stable(fault_level))
        else $error("result changed while stalled");

    // A pulse is only held while a mode runs
    a_pulse_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pulse_on |-> status == gps_pkg::STAT_BUSY)
        else $error("pulse reported while not busy");

    // Status stays within its codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == gps_pkg::STAT_IDLE) || (status == gps_pkg::STAT_BUSY)
                      || (status == gps_pkg::STAT_ERROR))
        else $error("undefined status code");

endmodule

bind glitch_pulse_sequencer_top gps_checker u_gps_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pulse_on    (pulse_on),
    .status      (status),
    .width_now   (width_now),
    .fault_level (fault_level)
);

`default_nettype wire
